@@ src/dotted_ipv4_address_parser_assert.svh @@
// Assertion macros for the dotted IPv4 address parser.
// Each macro expands to an empty body when SYNTHESIS is defined.
`ifndef DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH
`define DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define DIP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("parser check failed: implication");
`define DIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parser check failed: next-cycle implication");
`else
`define DIP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DIP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/dipv4p_pkg.sv @@
// Shared types and character codes for the dotted IPv4 address parser.
// No dependencies.
package dipv4p_pkg;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_ZERO   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_TRAIL  = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam int unsigned NUM_CLOSED = 3;

endpackage

@@ src/dotted_ipv4_address_parser.sv @@
// Dotted IPv4 address parser: top level, one character per transfer.
// Depends on dipv4p_pkg and dotted_ipv4_address_parser_assert.svh.

// Usage
//   req_ channel: one ASCII character of address text per transfer in
//   req_tdata. A NUL character (zero) ends the string.
//   rsp_ channel: one result per NUL. rsp_tdata carries the 32-bit address
//   (first part in bits 31..24, zero when the text is malformed) and
//   rsp_tuser flags whether the text was a well-formed address.
// Throughput: one character per cycle while req_tready is high, set by the
//   update of the part accumulator (constant-base shift-and-add) and the parse state.
// Result: registered; it appears on rsp_ in the cycle after the NUL transfer.
// Stall: the result register holds until taken; characters keep flowing while
//   no result waits or while the waiting one is taken in the same cycle. A
//   held result that is not taken stalls req_ for every character, not only
//   for the next NUL.
// Reset: synchronous, active high; clears parse state and the result valid.
//   No clearing pass is needed.
// After a malformed character or trailing whitespace, characters up to the
//   NUL are dropped; after the NUL the block is ready for the next string.

`include "dotted_ipv4_address_parser_assert.svh"

module dotted_ipv4_address_parser
   import dipv4p_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] address
   output logic        rsp_tuser    // [0] valid_res
);

   // parse state
   phase_type   phase_ff, phase_in;
   radix_type   radix_ff, radix_in;
   logic [31:0] accum_ff, accum_in;
   logic [1:0]  part_count_ff, part_count_in;
   logic [7:0]  part_low_byte_ff [NUM_CLOSED];
   logic        part_over_255_ff [NUM_CLOSED];

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic        accept;
   logic        is_nul;
   logic [7:0]  ch;
   logic [7:0]  ch_lower;
   logic        is_dec_digit;
   logic        is_hex_letter;
   logic        is_space;
   logic [3:0]  digit_val;
   radix_type   eff_radix;
   logic [31:0] accum_scaled;
   logic        close_part;
   logic        finish_ok;
   logic [31:0] finish_addr;

   // accept a character unless a result waits and a new one cannot displace it
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata;
   assign is_nul     = (ch == CH_NUL);

   // character classes
   assign ch_lower      = ch | CASE_BIT;
   assign is_dec_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_hex_letter = (eff_radix == RX_HEX) && (ch_lower >= CH_LO_A)
                          && (ch_lower <= CH_LO_F);
   assign is_space      = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));

   // after a leading zero the next character is taken as octal
   assign eff_radix = (phase_ff == PH_ZERO) ? RX_OCT : radix_ff;

   always_comb begin
      if (is_dec_digit) begin
         digit_val = ch[3:0];
      end else begin
         digit_val = ch_lower[3:0] + 4'd9;
      end
   end

   // accum * base as shifts; wraps modulo 2^32
   always_comb begin
      case (eff_radix)
         RX_HEX:  accum_scaled = accum_ff << 4;
         RX_OCT:  accum_scaled = accum_ff << 3;
         default: accum_scaled = (accum_ff << 3) + (accum_ff << 1);
      endcase
   end

   // close test for the address at the NUL
   always_comb begin
      finish_ok   = (phase_ff == PH_ZERO) || (phase_ff == PH_DIGITS)
                    || (phase_ff == PH_TRAIL);
      finish_addr = accum_ff;
      case (part_count_ff)
         2'd0: begin
         end
         2'd1: begin
            if ((accum_ff > 32'h00FF_FFFF) || part_over_255_ff[0]) begin
               finish_ok = 1'b0;
            end
            finish_addr = accum_ff | {part_low_byte_ff[0], 24'h0};
         end
         2'd2: begin
            if ((accum_ff > 32'h0000_FFFF) || part_over_255_ff[0]
                || part_over_255_ff[1]) begin
               finish_ok = 1'b0;
            end
            finish_addr = accum_ff
                          | {part_low_byte_ff[0], part_low_byte_ff[1], 16'h0};
         end
         default: begin
            if ((accum_ff > 32'h0000_00FF) || part_over_255_ff[0]
                || part_over_255_ff[1] || part_over_255_ff[2]) begin
               finish_ok = 1'b0;
            end
            finish_addr = accum_ff | {part_low_byte_ff[0], part_low_byte_ff[1],
                                      part_low_byte_ff[2], 8'h0};
         end
      endcase
      if (!finish_ok) begin
         finish_addr = 32'h0;
      end
   end

   // next parse state for one character
   always_comb begin
      phase_in      = phase_ff;
      radix_in      = radix_ff;
      accum_in      = accum_ff;
      part_count_in = part_count_ff;
      close_part    = 1'b0;
      if (is_nul) begin
         phase_in      = PH_START;
         radix_in      = RX_DEC;
         accum_in      = 32'h0;
         part_count_in = 2'd0;
      end else begin
         case (phase_ff)
            PH_START: begin
               radix_in = RX_DEC;
               if (ch == CH_ZERO) begin
                  accum_in = 32'h0;
                  phase_in = PH_ZERO;
               end else if ((ch >= CH_ONE) && (ch <= CH_NINE)) begin
                  accum_in = {28'h0, ch[3:0]};
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_ZERO, PH_DIGITS: begin
               phase_in = PH_DIGITS;
               if ((phase_ff == PH_ZERO) && ((ch == CH_LO_X) || (ch == CH_UP_X))) begin
                  radix_in = RX_HEX;
               end else begin
                  radix_in = eff_radix;
                  if (is_dec_digit || is_hex_letter) begin
                     accum_in = accum_scaled + {28'h0, digit_val};
                  end else if (ch == CH_DOT) begin
                     if (part_count_ff == 2'd3) begin
                        phase_in = PH_ERROR;
                     end else begin
                        close_part    = 1'b1;
                        part_count_in = part_count_ff + 2'd1;
                        accum_in      = 32'h0;
                        radix_in      = RX_DEC;
                        phase_in      = PH_START;
                     end
                  end else if (is_space) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
            end
            PH_TRAIL: begin
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   // result register: load on NUL, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && is_nul) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = finish_addr;
         rsp_ok_in    = finish_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         radix_ff      <= RX_DEC;
         accum_ff      <= 32'h0;
         part_count_ff <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            radix_ff      <= radix_in;
            accum_ff      <= accum_in;
            part_count_ff <= part_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
      if (accept && close_part) begin
         part_low_byte_ff[part_count_ff] <= accum_ff[7:0];
         part_over_255_ff[part_count_ff] <= (accum_ff > 32'h0000_00FF);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // a result appears only after a NUL transfer
   `DIP_ASSERT_IMPLY(a_rsp_after_nul, clock, reset, $rose(rsp_valid_ff),
                     $past(accept) && $past(is_nul))
   // a malformed string reports a zero address
   `DIP_ASSERT_IMPLY(a_bad_is_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff,
                     rsp_addr_ff == 32'h0)
   // the NUL leaves the parser ready for a new string
   `DIP_ASSERT_NEXT(a_nul_clears, clock, reset, accept && is_nul,
                    (phase_ff == PH_START) && (part_count_ff == 2'd0)
                    && (accum_ff == 32'h0))
   // a lone leading zero holds nothing in the accumulator
   `DIP_ASSERT_IMPLY(a_zero_empty, clock, reset, phase_ff == PH_ZERO,
                     accum_ff == 32'h0)

endmodule
